// ----- rtl/ici_pkg.sv -----
// Shared types and constants for the irradiance cache interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ici_pkg;

	typedef enum logic [1:0] {
		REQ_BEGIN  = 2'd0,
		REQ_CAND   = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// one queued word: request kind plus the raw payload
	typedef struct packed {
		req_t             kind;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] norm;
		logic [30:0]      radius;
		logic [2:0][31:0] irr;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_SQRT,
		ST_CHECK,
		ST_DIV,
		ST_WEIGHT,
		ST_PROD,
		ST_ACC,
		ST_FDIV,
		ST_EMIT
	} state_t;

	localparam logic signed [31:0] NDOT_MIN  = 32'sd2684355;   // 0.01 in Q2.28
	localparam logic signed [31:0] FRONT_MIN = -32'sd10737418; // -0.01 in Q.30
	localparam logic [16:0]        ONE_Q16   = 17'd65536;

endpackage
`default_nettype wire

// ----- rtl/ici_if.sv -----
// Handshake channels for request words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface ici_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [30:0]        radius;
	logic [31:0]        irr_in_r;
	logic [31:0]        irr_in_g;
	logic [31:0]        irr_in_b;

	modport source (output valid, req_type, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		radius, irr_in_r, irr_in_g, irr_in_b, input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		radius, irr_in_r, irr_in_g, irr_in_b, output ready);
endinterface

interface ici_res_if;
	logic        valid;
	logic        ready;
	logic        success;
	logic [31:0] irr_out_r;
	logic [31:0] irr_out_g;
	logic [31:0] irr_out_b;
	logic [15:0] found_count;
	logic [15:0] checked_count;

	modport source (output valid, success, irr_out_r, irr_out_g, irr_out_b, found_count,
		checked_count, input ready);
	modport sink (input valid, success, irr_out_r, irr_out_g, irr_out_b, found_count,
		checked_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/irradiance_cache_interpolator.sv -----
// Top level: front queue plus weighting back end.
//
//  channel  dir  word
//  req_ch   in   req_type, pos_x/y/z, norm_x/y/z, radius, irr_in_r/g/b
//  res_ch   out  success, irr_out_r/g/b, found_count, checked_count
//
// Begin words are handled in the idle state. A candidate that the normal/radius/
// front tests reject leaves after the check states C1 to C4; an accepted one goes
// on through the bit-serial square root and the error divide. Finish goes to the
// emit state, after the 64-step mean divide if any weight was summed. Reset clears
// all sums and the query. The two-entry queue keeps accepting while the back end
// works or a result waits in the output register, until both entries are full.
`timescale 1ns / 1ps
`default_nettype none
module irradiance_cache_interpolator #(
	parameter int MAX_CANDIDATES = 65535
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ici_req_if.sink   req_ch,
	ici_res_if.source res_ch
);
	import ici_pkg::*;

	head_t head;
	logic  pop;

	ici_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.pop    (pop),
		.head   (head)
	);

	ici_back #(
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.res_ch (res_ch)
	);

endmodule
`default_nettype wire

// ----- rtl/ici_front.sv -----
// Front end: accepts request words, drops unknown codes, two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module ici_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ici_req_if.sink            req_ch,
	input  wire logic          pop,
	output ici_pkg::head_t     head
);
	import ici_pkg::*;

	item_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;
	item_t       item;

	assign req_ch.ready = (cnt_q != 2'd2);
	assign push = req_ch.valid && req_ch.ready && (req_t'(req_ch.req_type) != REQ_NONE);

	always_comb begin
		item.kind   = req_t'(req_ch.req_type);
		item.pos    = {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};
		item.norm   = {req_ch.norm_z, req_ch.norm_y, req_ch.norm_x};
		item.radius = req_ch.radius;
		item.irr    = {req_ch.irr_in_b, req_ch.irr_in_g, req_ch.irr_in_r};
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop && head.valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop && head.valid);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ici_back.sv -----
// Back end: sequencer for query setup, record weighting and the final mean.
`timescale 1ns / 1ps
`default_nettype none
module ici_back #(
	parameter int MAX_CANDIDATES = 65535
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  ici_pkg::head_t     head,
	output logic               pop,
	ici_res_if.source          res_ch
);
	import ici_pkg::*;

	localparam logic [15:0] CNT_MAX = 16'(MAX_CANDIDATES);

	state_t state_q, state_d;

	// query and accumulators
	logic [2:0][31:0] qp_q;
	logic [2:0][15:0] qn_q;
	logic [2:0][63:0] wsum_q;
	logic [31:0]      wtot_q;
	logic [15:0]      acc_cnt_q;
	logic [15:0]      exam_cnt_q;

	item_t cur_q;

	// record pipeline
	logic signed [33:0]       ndot_s1;
	logic [2:0][32:0]         diff_s1;
	logic [2:0][32:0]         absd_s1;
	logic [2:0][16:0]         nsum_s1;
	logic                     skip_s2;
	logic [2:0][61:0]         sq_s2;
	logic [61:0]              rsq_s2;
	logic [2:0][49:0]         fr_s2;
	logic                     skip_s3;
	logic [63:0]              d2_s3;
	logic [61:0]              rsq_s3;
	logic signed [51:0]       front_s3;
	logic [62:0]              prod_q;

	// iterative units
	logic [63:0]      sv_q;
	logic [35:0]      srem_q;
	logic [31:0]      root_q;
	logic [6:0]       it_q;
	logic [62:0]      drem_q;
	logic [15:0]      err_q;
	logic [15:0]      wt_q;
	logic [2:0][47:0] wp_q;
	logic [2:0][63:0] dvd_q;
	logic [2:0][32:0] frem_q;
	logic [2:0][31:0] quo_q;
	logic             ok_q;

	// output register
	logic             ovalid_q;
	logic             osucc_q;
	logic [2:0][31:0] oirr_q;
	logic [15:0]      ofound_q;
	logic [15:0]      ocheck_q;

	logic             slot_free;
	logic             rec_skip;
	logic [59:0]      num;
	logic [35:0]      s_next;
	logic [35:0]      s_trial;
	logic [63:0]      d_next;
	logic [16:0]      om;
	logic [33:0]      omsq;
	logic             fin_ok;

	assign slot_free = !ovalid_q || res_ch.ready;
	assign rec_skip  = skip_s3 || (d2_s3 > 64'(rsq_s3)) || (front_s3 < 52'(FRONT_MIN));
	assign num       = {root_q, 28'd0};
	assign s_next    = {srem_q[33:0], sv_q[63:62]};
	assign s_trial   = {2'b00, root_q, 2'b01};
	assign d_next    = {drem_q, 1'b0};
	assign om        = ONE_Q16 - 17'(err_q);
	assign omsq      = om * om;
	assign fin_ok    = (wtot_q != 32'd0) && (acc_cnt_q != 16'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					case (head.item.kind)
						REQ_CAND:   state_d = ST_C1;
						REQ_FINISH: state_d = fin_ok ? ST_FDIV : ST_EMIT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_C1:     state_d = ST_C2;
			ST_C2:     state_d = ST_C3;
			ST_C3:     state_d = ST_C4;
			ST_C4:     state_d = rec_skip ? ST_IDLE : ST_SQRT;
			ST_SQRT:   state_d = (it_q == 7'd31) ? ST_CHECK : ST_SQRT;
			ST_CHECK: begin
				if ((63'(num) < prod_q) && (acc_cnt_q < CNT_MAX)) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV:    state_d = (it_q == 7'd15) ? ST_WEIGHT : ST_DIV;
			ST_WEIGHT: state_d = ST_PROD;
			ST_PROD:   state_d = ST_ACC;
			ST_ACC:    state_d = ST_IDLE;
			ST_FDIV:   state_d = (it_q == 7'd63) ? ST_EMIT : ST_FDIV;
			ST_EMIT:   state_d = slot_free ? ST_IDLE : ST_EMIT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop = 1'b0;
		case (state_q)
			ST_IDLE: pop = head.valid;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ovalid_q   <= 1'b0;
			qp_q       <= '0;
			qn_q       <= '0;
			wsum_q     <= '0;
			wtot_q     <= '0;
			acc_cnt_q  <= '0;
			exam_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && slot_free) begin
				ovalid_q <= 1'b1;
			end else if (res_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid && head.item.kind == REQ_BEGIN) begin
						qp_q       <= head.item.pos;
						qn_q       <= head.item.norm;
						wsum_q     <= '0;
						wtot_q     <= '0;
						acc_cnt_q  <= '0;
						exam_cnt_q <= '0;
					end
				end
				ST_C1: begin
					if (exam_cnt_q < CNT_MAX) begin
						exam_cnt_q <= exam_cnt_q + 16'd1;
					end
				end
				ST_ACC: begin
					for (int i = 0; i < 3; i++) begin
						wsum_q[i] <= wsum_q[i] + 64'(wp_q[i]);
					end
					wtot_q    <= wtot_q + 32'(wt_q);
					acc_cnt_q <= acc_cnt_q + 16'd1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q <= head.item;
				it_q  <= '0;
				ok_q  <= fin_ok;
				for (int i = 0; i < 3; i++) begin
					dvd_q[i]  <= wsum_q[i];
					frem_q[i] <= '0;
					quo_q[i]  <= '0;
				end
			end
			ST_C1: begin
				ndot_s1 <= 34'($signed(qn_q[0]) * $signed(cur_q.norm[0]))
					+ 34'($signed(qn_q[1]) * $signed(cur_q.norm[1]))
					+ 34'($signed(qn_q[2]) * $signed(cur_q.norm[2]));
				for (int i = 0; i < 3; i++) begin
					diff_s1[i] <= 33'($signed(qp_q[i])) - 33'($signed(cur_q.pos[i]));
					absd_s1[i] <= $signed(33'($signed(qp_q[i])) - 33'($signed(cur_q.pos[i]))) < 0
						? 33'($signed(cur_q.pos[i])) - 33'($signed(qp_q[i]))
						: 33'($signed(qp_q[i])) - 33'($signed(cur_q.pos[i]));
					nsum_s1[i] <= 17'($signed(cur_q.norm[i])) + 17'($signed(qn_q[i]));
				end
			end
			ST_C2: begin
				skip_s2 <= (ndot_s1 < 34'(NDOT_MIN))
					|| (absd_s1[0] > 33'(cur_q.radius))
					|| (absd_s1[1] > 33'(cur_q.radius))
					|| (absd_s1[2] > 33'(cur_q.radius));
				rsq_s2 <= 62'(cur_q.radius) * 62'(cur_q.radius);
				for (int i = 0; i < 3; i++) begin
					sq_s2[i] <= 62'(absd_s1[i][30:0]) * 62'(absd_s1[i][30:0]);
					fr_s2[i] <= 50'($signed(diff_s1[i]) * $signed(nsum_s1[i]));
				end
				// ndot is positive here unless skipped; out-of-range normals reach 32 bits
				prod_q <= 63'(cur_q.radius) * 63'(ndot_s1[31:0]);
			end
			ST_C3: begin
				skip_s3  <= skip_s2;
				rsq_s3   <= rsq_s2;
				d2_s3    <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
				front_s3 <= 52'($signed(fr_s2[0])) + 52'($signed(fr_s2[1]))
					+ 52'($signed(fr_s2[2]));
			end
			ST_C4: begin
				sv_q   <= d2_s3;
				srem_q <= '0;
				root_q <= '0;
				it_q   <= '0;
			end
			ST_SQRT: begin
				// one root bit per cycle, two radicand bits consumed
				sv_q <= {sv_q[61:0], 2'b00};
				if (s_next >= s_trial) begin
					srem_q <= s_next - s_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= s_next;
					root_q <= {root_q[30:0], 1'b0};
				end
				it_q <= it_q + 7'd1;
			end
			ST_CHECK: begin
				drem_q <= 63'(num);
				err_q  <= '0;
				it_q   <= '0;
			end
			ST_DIV: begin
				if (d_next >= 64'(prod_q)) begin
					drem_q <= 63'(d_next - 64'(prod_q));
					err_q  <= {err_q[14:0], 1'b1};
				end else begin
					drem_q <= d_next[62:0];
					err_q  <= {err_q[14:0], 1'b0};
				end
				it_q <= it_q + 7'd1;
			end
			ST_WEIGHT: begin
				wt_q <= (omsq[33:16] > 18'h0FFFF) ? 16'hFFFF : omsq[31:16];
			end
			ST_PROD: begin
				for (int i = 0; i < 3; i++) begin
					wp_q[i] <= 48'(wt_q) * 48'(cur_q.irr[i]);
				end
			end
			ST_FDIV: begin
				// restoring divide, three channels side by side
				for (int i = 0; i < 3; i++) begin
					dvd_q[i] <= {dvd_q[i][62:0], 1'b0};
					if ({frem_q[i][31:0], dvd_q[i][63]} >= 33'(wtot_q)) begin
						frem_q[i] <= {frem_q[i][31:0], dvd_q[i][63]} - 33'(wtot_q);
						quo_q[i]  <= {quo_q[i][30:0], 1'b1};
					end else begin
						frem_q[i] <= {frem_q[i][31:0], dvd_q[i][63]};
						quo_q[i]  <= {quo_q[i][30:0], 1'b0};
					end
				end
				it_q <= it_q + 7'd1;
			end
			ST_EMIT: begin
				if (slot_free) begin
					osucc_q  <= ok_q;
					oirr_q   <= quo_q;
					ofound_q <= acc_cnt_q;
					ocheck_q <= exam_cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign res_ch.valid         = ovalid_q;
	assign res_ch.success       = osucc_q;
	assign res_ch.irr_out_r     = oirr_q[0];
	assign res_ch.irr_out_g     = oirr_q[1];
	assign res_ch.irr_out_b     = oirr_q[2];
	assign res_ch.found_count   = ofound_q;
	assign res_ch.checked_count = ocheck_q;

endmodule
`default_nettype wire

// ----- verif/irradiance_cache_interpolator_tb.sv -----
// Testbench for the irradiance cache interpolator: table and random words vs. a predictor.
`timescale 1ns / 1ps
`default_nettype none
module irradiance_cache_interpolator_tb;
	import ici_pkg::*;

	typedef struct packed {
		req_t kind;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] norm;
		logic [30:0] radius;
		logic [2:0][31:0] irr;
	} word_t;

	typedef struct packed {
		logic success;
		logic [2:0][31:0] irr;
		logic [15:0] found;
		logic [15:0] checked;
	} interp_t;

	typedef struct {
		word_t w;
		bit has_exp;
		interp_t exp_val;
	} row_t;

	localparam int LIMIT = 4000000;

	logic clk;
	logic arst_n;
	ici_req_if req_ch ();
	ici_res_if res_ch ();

	irradiance_cache_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch.sink),
		.res_ch(res_ch.source)
	);

	// predictor state
	logic [2:0][31:0] q_point;
	logic [2:0][15:0] q_normal;
	logic [2:0][63:0] irr_sum;
	logic [31:0] wt_sum;
	logic [15:0] n_found;
	logic [15:0] n_checked;

	interp_t mean_q[$];
	int errors;
	int sent_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int cycles;

	function automatic logic [31:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'h1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	task automatic weigh_record(word_t w);
		longint ndot, front, dd, a;
		logic [63:0] r, d2, prod, num, rem;
		logic [31:0] root_d, err, om, wt;
		longint diff [3];
		ndot = 0;
		front = 0;
		d2 = 0;
		r = {33'd0, w.radius};
		if (n_checked < 16'hFFFF) n_checked++;
		for (int i = 0; i < 3; i++)
			ndot += longint'($signed(q_normal[i])) * longint'($signed(w.norm[i]));
		if (ndot < 2684355) return;
		for (int i = 0; i < 3; i++) begin
			dd = longint'($signed(q_point[i])) - longint'($signed(w.pos[i]));
			diff[i] = dd;
			a = dd < 0 ? -dd : dd;
			if (a > r) return;
			d2 += a * a;
		end
		if (d2 > r * r) return;
		for (int i = 0; i < 3; i++)
			front += diff[i] * (longint'($signed(w.norm[i])) + longint'($signed(q_normal[i])));
		if (front < -10737418) return;
		root_d = int_sqrt(d2);
		prod = r * ndot;
		num = {root_d, 28'd0};
		if (!(num < prod)) return;
		if (n_found >= 16'hFFFF) return;
		rem = num;
		err = 0;
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			err = err << 1;
			if (rem >= prod) begin
				rem = rem - prod;
				err[0] = 1'b1;
			end
		end
		om = 32'd65536 - err;
		wt = 32'(({32'd0, om} * om) >> 16);
		if (wt > 32'hFFFF) wt = 32'hFFFF;
		n_found++;
		for (int i = 0; i < 3; i++) irr_sum[i] += {32'd0, wt} * w.irr[i];
		wt_sum += wt;
	endtask

	function automatic interp_t current_mean();
		interp_t o;
		logic [63:0] qv;
		o.success = (wt_sum > 0) && (n_found > 0);
		for (int i = 0; i < 3; i++) begin
			qv = o.success ? irr_sum[i] / wt_sum : 64'd0;
			o.irr[i] = qv[31:0];
		end
		o.found = n_found;
		o.checked = n_checked;
		return o;
	endfunction

	task automatic track_word(word_t w);
		case (w.kind)
			REQ_BEGIN: begin
				q_point = w.pos;
				q_normal = w.norm;
				irr_sum = '0;
				wt_sum = 0;
				n_found = 0;
				n_checked = 0;
			end
			REQ_CAND: weigh_record(w);
			REQ_FINISH: mean_q.push_back(current_mean());
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (mean_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word %h", res_ch.success);
				end else begin
					interp_t e;
					interp_t g;
					e = mean_q.pop_front();
					g = {res_ch.success, res_ch.irr_out_b, res_ch.irr_out_g, res_ch.irr_out_r,
						res_ch.found_count, res_ch.checked_count};
					if (g !== e) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp ok=%0d irr=%h f=%0d c=%0d got ok=%0d irr=%h f=%0d c=%0d",
								e.success, e.irr, e.found, e.checked,
								g.success, g.irr, g.found, g.checked);
					end
				end
			end
			res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [15:0] rand_norm();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic word_t rand_word(word_t qry, int mode);
		word_t w;
		int k;
		logic [31:0] r;
		w.pos = {$urandom, $urandom, $urandom};
		w.norm = {rand_norm(), rand_norm(), rand_norm()};
		w.radius = 31'($urandom);
		w.irr = {$urandom, $urandom, $urandom};
		k = $urandom_range(99);
		w.kind = k < 8 ? REQ_BEGIN : k < 86 ? REQ_CAND : k < 97 ? REQ_FINISH : REQ_NONE;
		if (mode == 0 || w.kind != REQ_CAND) return w;
		// near-query record: small offset, similar normal, radius a bit larger
		r = $urandom_range(20'hFFFFF, 1);
		for (int i = 0; i < 3; i++) begin
			w.pos[i] = qry.pos[i] + 32'($signed($urandom_range(2 * r / 3)) - $signed(r / 3));
			w.norm[i] = qry.norm[i] + 16'($signed($urandom_range(600)) - 300);
		end
		w.radius = 31'(r);
		if ($urandom_range(9) == 0) w.radius = 31'h7FFFFFFF >> $urandom_range(30);
		return w;
	endfunction

	// valid stays high after a word so the next one can follow at once
	task automatic send(word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sent_idle_pct) gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		{req_ch.req_type, req_ch.pos_z, req_ch.pos_y, req_ch.pos_x,
			req_ch.norm_z, req_ch.norm_y, req_ch.norm_x, req_ch.radius,
			req_ch.irr_in_b, req_ch.irr_in_g, req_ch.irr_in_r} <= w;
		do @(posedge clk); while (!req_ch.ready);
		track_word(w);
	endtask

	row_t dir_tab [$];

	task automatic add_row(word_t w, bit he, interp_t ev);
		row_t rw;
		rw.w = w;
		rw.has_exp = he;
		rw.exp_val = ev;
		dir_tab.push_back(rw);
	endtask

	initial begin
		word_t w, qry;
		interp_t zero_res;
		int mode;
		errors = 0;
		hold_off = 1'b0;
		sent_idle_pct = 0;
		recv_stall_pct = 0;
		q_point = '0; q_normal = '0; irr_sum = '0; wt_sum = 0; n_found = 0; n_checked = 0;
		req_ch.valid = 1'b0;
		{req_ch.req_type, req_ch.pos_z, req_ch.pos_y, req_ch.pos_x,
			req_ch.norm_z, req_ch.norm_y, req_ch.norm_x, req_ch.radius,
			req_ch.irr_in_b, req_ch.irr_in_g, req_ch.irr_in_r} = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		zero_res = '0;
		w = '0;
		w.kind = REQ_FINISH;
		add_row(w, 1, zero_res);                       // after reset
		w.kind = REQ_CAND;
		add_row(w, 0, zero_res);                       // candidate before begin
		w.kind = REQ_NONE;
		w.pos = '1; w.norm = '1; w.radius = '1; w.irr = '1;
		add_row(w, 0, zero_res);                       // ignored request
		w = '0;
		w.kind = REQ_BEGIN;
		w.norm = {16'sd16384, 16'sd0, 16'sd0};
		add_row(w, 0, zero_res);
		w.kind = REQ_CAND;
		w.irr = '1;
		add_row(w, 0, zero_res);                       // zero radius
		w.radius = 31'h7FFFFFFF;
		add_row(w, 0, zero_res);                       // exact hit, max radius
		w.pos = {32'h0000_1000, 32'h0, 32'h0};
		w.radius = 31'h0001_0000;
		w.irr = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
		add_row(w, 0, zero_res);
		w.pos = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		w.radius = 31'h7FFFFFFF;
		add_row(w, 0, zero_res);                       // extreme positions
		w.pos = '0;
		w.norm = {-16'sd16384, 16'sd0, 16'sd0};
		add_row(w, 0, zero_res);                       // opposite normals
		w.norm = {16'h7FFF, 16'h8000, 16'h7FFF};
		add_row(w, 0, zero_res);                       // out-of-range normals
		w.norm = {16'sd16384, 16'sd0, 16'sd0};
		w.pos = {32'h0, 32'h0, 32'h0002_0000};
		w.radius = 31'h0001_0000;
		add_row(w, 0, zero_res);                       // record in front
		w.pos = {32'h0, 32'h0, 32'hFFFF_F000};
		add_row(w, 0, zero_res);                       // record behind
		w.pos = {32'h0, 32'h0000_FFFF, 32'h0};
		add_row(w, 0, zero_res);                       // near radius edge, tiny weight
		w.kind = REQ_FINISH;
		add_row(w, 0, zero_res);
		add_row(w, 0, zero_res);                       // repeated finish
		w = '0;
		w.kind = REQ_BEGIN;
		w.pos = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		w.norm = {16'sd0, -16'sd16384, 16'sd0};
		add_row(w, 0, zero_res);
		w.kind = REQ_FINISH;
		add_row(w, 1, zero_res);                       // no records used

		foreach (dir_tab[i]) begin
			if (dir_tab[i].has_exp) begin
				interp_t p;
				p = current_mean();
				if (p !== dir_tab[i].exp_val) begin
					errors++;
					if (errors <= 10) $display("table row %0d: predictor disagrees", i);
				end
			end
			send(dir_tab[i].w);
		end

		qry = '0;
		for (int ph = 0; ph < 5; ph++) begin
			sent_idle_pct = ph == 1 ? 73 : ph == 3 ? 28 : 0;
			recv_stall_pct = ph == 2 ? 73 : ph == 3 ? 28 : 0;
			if (ph == 4) begin
				hold_off = 1'b1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < 190; n++) begin
				mode = $urandom_range(9) < 8;
				w = rand_word(qry, mode);
				if (ph == 4 && n < 40) w.kind = n % 4 == 3 ? REQ_FINISH : REQ_CAND;
				if (w.kind == REQ_BEGIN) qry = w;
				send(w);
				if (ph < 4 && n % 64 == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(200, 1)) @(posedge clk);
				end
			end
		end
		req_ch.valid <= 1'b0;

		while (mean_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
